>>> hdl/nmea_sentence_checksum_framer_assert.svh
// Assertion macros shared by the NMEA checksum framer RTL.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef NMEA_SENTENCE_CHECKSUM_FRAMER_ASSERT_SVH
`define NMEA_SENTENCE_CHECKSUM_FRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NSCF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nscf assertion failed");

// Next-cycle implication, checked outside reset.
`define NSCF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nscf assertion failed");

`endif

>>> hdl/nscf_pkg.sv
// Package for the NMEA checksum framer: character codes, the title table,
// the sentence record type and the decode helpers. Depends on nothing.
`timescale 1ns / 1ps

package nscf_pkg;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam int         TITLE_LEN  = 5;
    localparam int         NUM_TITLES = 21;
    localparam int         Q_DEPTH    = 2;

    // First title character sits in the top byte, as the front shifts it in.
    localparam logic [39:0] TITLES [NUM_TITLES] = '{
        "GPRMC", "GPVTG", "GPTXT", "GPGGA", "GPGSA", "GPGSV", "GPGLL",
        "GNRMC", "GNVTG", "GNGSA", "GNGGA", "GPZDA", "GNZDA", "GLZDA",
        "PRDCU", "GLGSV", "GLGSA", "GLGGA", "GLRMC", "GLVTG", "GNGLL"
    };

    // One finished sentence as handed from the parser to the classifier.
    typedef struct packed {
        logic        title_ok;
        logic [39:0] title;
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
    } t_sentence;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

    function automatic logic [4:0] title_code(input logic ok, input logic [39:0] t);
        logic [4:0] code;
        code = 5'd0;
        for (int i = NUM_TITLES - 1; i >= 0; i--) begin
            if (ok && t == TITLES[i]) begin
                code = 5'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

>>> hdl/nscf_ifs.sv
// Valid/ready channel interfaces for the framer's byte input and result output.
// Depends on nothing.
`timescale 1ns / 1ps

interface nscf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nscf_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] sentence_type;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic       sum_ok;

    modport source (output valid, output sentence_type, output computed_sum,
                    output received_sum, output sum_ok, input ready);
    modport sink   (input valid, input sentence_type, input computed_sum,
                    input received_sum, input sum_ok, output ready);
endinterface

>>> hdl/nscf_front.sv
// Sentence parser: framing, running XOR, title capture and hex digit decode.
// Depends on nscf_pkg.
`timescale 1ns / 1ps

module nscf_front
    import nscf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_ready,
    output logic       o_push,
    output t_sentence  o_rec,
    input  logic       i_q_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BODY,
        S_HEX1,
        S_HEX2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_count, n_count;
    logic [39:0] r_title, n_title;
    logic [7:0]  r_xor,   n_xor;
    logic [3:0]  r_nib,   n_nib;
    logic        w_accept;

    // Only the second checksum digit needs room in the queue.
    assign o_ready  = (r_phase != S_HEX2) || i_q_ready;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_title = r_title;
        n_xor   = r_xor;
        n_nib   = r_nib;
        o_push  = 1'b0;
        o_rec.title_ok     = (r_count == 3'(TITLE_LEN));
        o_rec.title        = r_title;
        o_rec.computed_sum = r_xor;
        o_rec.received_sum = {r_nib, hex_value(i_rx_byte)};
        if (w_accept) begin
            if (i_rx_byte == CH_DOLLAR) begin
                n_phase = S_BODY;
                n_count = 3'd0;
                n_title = 40'd0;
                n_xor   = 8'd0;
                n_nib   = 4'd0;
            end else begin
                unique case (r_phase)
                    S_BODY: begin
                        if (i_rx_byte == CH_STAR) begin
                            n_phase = S_HEX1;
                        end else begin
                            n_xor = r_xor ^ i_rx_byte;
                            if (r_count < 3'(TITLE_LEN)) begin
                                n_title = {r_title[31:0], i_rx_byte};
                                n_count = 3'(r_count + 3'd1);
                            end
                        end
                    end
                    S_HEX1: begin
                        n_nib   = hex_value(i_rx_byte);
                        n_phase = S_HEX2;
                    end
                    S_HEX2: begin
                        o_push  = 1'b1;
                        n_phase = S_IDLE;
                    end
                    default: begin
                        n_phase = S_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_IDLE;
            r_count <= 3'd0;
            r_title <= 40'd0;
            r_xor   <= 8'd0;
            r_nib   <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_title <= n_title;
            r_xor   <= n_xor;
            r_nib   <= n_nib;
        end
    end

endmodule

>>> hdl/nscf_queue.sv
// Two-entry queue of finished sentence records between parser and classifier.
// Depends on nscf_pkg.
`timescale 1ns / 1ps

module nscf_queue
    import nscf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_sentence i_rec,
    output logic      o_ready,
    output logic      o_valid,
    output t_sentence o_rec,
    input  logic      i_pop
);

    t_sentence  r_mem [Q_DEPTH];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'(Q_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_rec   = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= 2'(r_cnt + {1'b0, w_push} - {1'b0, w_pop});
        end
        if (w_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule

>>> hdl/nscf_back.sv
// Classifier and output register: title lookup, checksum compare, result hold.
// Depends on nscf_pkg.
`timescale 1ns / 1ps

module nscf_back
    import nscf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_sentence  i_rec,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [4:0] o_sentence_type,
    output logic [7:0] o_computed_sum,
    output logic [7:0] o_received_sum,
    output logic       o_sum_ok
);

    logic       r_valid;
    logic [4:0] r_type;
    logic [7:0] r_csum, r_rsum;
    logic       r_ok;

    // Load whenever the output slot is empty or being emptied this cycle.
    assign o_pop = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_type <= title_code(i_rec.title_ok, i_rec.title);
            r_csum <= i_rec.computed_sum;
            r_rsum <= i_rec.received_sum;
            r_ok   <= (i_rec.computed_sum == i_rec.received_sum);
        end
    end

    assign o_valid         = r_valid;
    assign o_sentence_type = r_type;
    assign o_computed_sum  = r_csum;
    assign o_received_sum  = r_rsum;
    assign o_sum_ok        = r_ok;

endmodule

>>> hdl/nmea_sentence_checksum_framer.sv
// Top level of the NMEA 0183 sentence checksum framer.
// Depends on nscf_pkg, nscf_ifs, nscf_front, nscf_queue, nscf_back and the assert header.
//
//   Channel   Direction  Payload                                         Per item
//   i_rx      in         rx_byte[7:0]                                    one character
//   o_res     out        sentence_type[4:0] computed_sum[7:0]
//                        received_sum[7:0] sum_ok                        one sentence
//
// One character is taken per clock unless a second hex digit waits for queue room; the parser state is registered.
// A sentence result passes from its last hex digit into the record queue, and from there
// through the title lookup and compare into the output register.
// Reset is synchronous and active low; it idles the parser and empties queue and output.
// With the output stalled, two records wait in the queue and one in the output register;
// the parser keeps taking body characters and holds only on a second hex digit with no room.
`timescale 1ns / 1ps

`include "nmea_sentence_checksum_framer_assert.svh"

module nmea_sentence_checksum_framer
    import nscf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    nscf_in_if.sink    i_rx,
    nscf_out_if.source o_res
);

    logic      w_push;
    logic      w_q_ready;
    logic      w_q_valid;
    logic      w_pop;
    t_sentence w_rec_in;
    t_sentence w_rec_out;

    // The front parses characters and pushes a record when a sentence completes.
    nscf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx.valid),
        .i_rx_byte (i_rx.rx_byte),
        .o_ready   (i_rx.ready),
        .o_push    (w_push),
        .o_rec     (w_rec_in),
        .i_q_ready (w_q_ready)
    );

    // The queue decouples parsing from a stalled result consumer.
    nscf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_rec   (w_rec_out),
        .i_pop   (w_pop)
    );

    // The back classifies the title and presents the registered result.
    nscf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .i_rec           (w_rec_out),
        .o_pop           (w_pop),
        .o_valid         (o_res.valid),
        .i_ready         (o_res.ready),
        .o_sentence_type (o_res.sentence_type),
        .o_computed_sum  (o_res.computed_sum),
        .o_received_sum  (o_res.received_sum),
        .o_sum_ok        (o_res.sum_ok)
    );

    // A record is produced only by an accepted character that is not a dollar.
    `NSCF_ASSERT_NOW(a_push_on_accept, w_push, i_rx.valid && i_rx.ready && i_rx.rx_byte != CH_DOLLAR)
    // The parser never completes a sentence into a full queue.
    `NSCF_ASSERT_NOW(a_no_overflow, w_push, w_q_ready)
    // The match flag always agrees with the two sums it reports.
    `NSCF_ASSERT_NOW(a_flag_matches, o_res.valid, o_res.sum_ok == (o_res.computed_sum == o_res.received_sum))
    // A record popped from the queue shows up as a valid result next cycle.
    `NSCF_ASSERT_NEXT(a_pop_to_out, w_pop, o_res.valid)

endmodule
